### design/scrp_pkg.sv
// Shared types and constants for the strip chart rectangle plotter.
package scrp_pkg;

	// Field widths of the input and result items.
	localparam int SAMPLE_W = 16;
	localparam int COORD_W  = 12;
	localparam int RECT_W   = 14;
	localparam int COLOR_W  = 24;
	localparam int FS_W     = 15;

	// Configuration register indexes.
	typedef logic [1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_FULL_SCALE  = 2'd0;
	localparam cfg_idx_t CFG_POINT_COLOR = 2'd1;
	localparam cfg_idx_t CFG_BAR_COLOR   = 2'd2;

	// Item kinds carried on tuser.
	localparam logic KIND_ADD    = 1'b0;
	localparam logic KIND_RENDER = 1'b1;

	// Scaled numerator magnitude and the split used by the serial divider.
	localparam int NUM_W     = 28;
	localparam int QUOT_W    = 13;
	localparam int DIV_STEPS = QUOT_W;
	localparam int WDIV_STEPS = COORD_W;
	localparam int CNT_W     = 4;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WDIV,
		ST_BAR,
		ST_PMUL,
		ST_PSUM,
		ST_PDIV,
		ST_PEMIT
	} st_t;

endpackage

### design/strip_chart_rect_plotter_unit.sv
// Strip chart rectangle plotter: sample history, render sequencer and serial dividers.
//
// The block keeps the last HISTORY_DEPTH samples in a shift register. An input
// transaction with tuser = add shifts one sample in; it is taken while idle and
// gives no result. A transaction with tuser = render gives HISTORY_DEPTH+1 result
// transactions: a bar rectangle, then one trace rectangle per history entry, the
// final one with tlast set.
// A render first divides area_width by HISTORY_DEPTH bit-serially, then emits
// the bar. Each trace point then takes a multiply, an add, the steps of a
// restoring divider that produces one quotient bit per cycle against
// full_scale, and a step to load the output register.
// The history is rotated one place per point so that only entry 0 is read; after
// a render it is back in its original order.
// A stalled receiver holds the block in its emit step; the sequencer waits until
// the output register is free. Once the last rectangle is in the output register
// the block accepts new input again. Reset clears the history to zero, sets
// full_scale to 32767 and both colors to zero. Configuration writes are taken
// at any edge with cfg_we high.
module strip_chart_rect_plotter_unit #(
	parameter int HISTORY_DEPTH = 32,
	parameter int PAD           = 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// Configuration write port.
	input  logic                      cfg_we,
	input  scrp_pkg::cfg_idx_t        cfg_index,
	input  logic [23:0]               cfg_data,
	// Input stream.
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// s_tdata, lowest bit up: sample[15:0], origin_x[27:16], origin_y[39:28],
	// area_width[51:40], area_height[63:52].
	input  logic [63:0]               s_tdata,
	// s_tuser: kind.
	input  logic                      s_tuser,
	// Output stream.
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// m_tdata, lowest bit up: rect_x[13:0], rect_y[27:14], rect_w[41:28],
	// rect_h[55:42], rect_color[79:56].
	output logic [79:0]               m_tdata,
	output logic                      m_tlast
);
	import scrp_pkg::*;

	localparam int IW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

	// Configuration registers.
	logic [FS_W-1:0]    full_scale_q;
	logic [COLOR_W-1:0] point_color_q;
	logic [COLOR_W-1:0] bar_color_q;

	// Sequencer and render context.
	st_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic [IW-1:0]    idx_q;
	logic signed [COORD_W-1:0] ox_q, oy_q;
	logic [COORD_W-1:0] w_q, h_q;
	logic signed [26:0] off_q;

	// Width divider and x stepping.
	logic [COORD_W-1:0] wsh_q;
	logic [IW-1:0]      wrem_q;
	logic [COORD_W-1:0] qx_q;
	logic [IW-1:0]      rx_q;

	// Point datapath.
	logic signed [SAMPLE_W-1:0] hist_q [HISTORY_DEPTH];
	logic signed [28:0]  prod_q;
	logic                neg_q;
	logic [FS_W-1:0]     rem_q;
	logic [QUOT_W-1:0]   dsh_q;
	logic signed [RECT_W-1:0] px_q, py_q;

	// Output register.
	logic                 m_tvalid_q;
	logic [RECT_W-1:0]    ox_out_q, oy_out_q, ow_out_q, oh_out_q;
	logic [COLOR_W-1:0]   oc_out_q;
	logic                 olast_q;

	// Control strobes.
	logic in_acc, add_acc, render_acc, out_free, out_load, last_pt;

	logic [FS_W-1:0] fs_eff;
	assign fs_eff = (full_scale_q == '0) ? FS_W'(1) : full_scale_q;

	// Configuration writes; out of range indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_scale_q  <= FS_W'(32767);
			point_color_q <= '0;
			bar_color_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FULL_SCALE:  full_scale_q  <= cfg_data[FS_W-1:0];
				CFG_POINT_COLOR: point_color_q <= cfg_data;
				CFG_BAR_COLOR:   bar_color_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Handshake strobes.
	assign out_free   = !m_tvalid_q || m_tready;
	assign in_acc     = s_tvalid && s_tready;
	assign add_acc    = in_acc && (s_tuser == KIND_ADD);
	assign render_acc = in_acc && (s_tuser == KIND_RENDER);
	assign last_pt    = (idx_q == IW'(HISTORY_DEPTH - 1));

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (render_acc) state_d = ST_WDIV;
			ST_WDIV:  if (cnt_q == CNT_W'(WDIV_STEPS - 1)) state_d = ST_BAR;
			ST_BAR:   if (out_free) state_d = ST_PMUL;
			ST_PMUL:  state_d = ST_PSUM;
			ST_PSUM:  state_d = ST_PDIV;
			ST_PDIV:  if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_d = ST_PEMIT;
			ST_PEMIT: begin
				if (out_free) state_d = last_pt ? ST_IDLE : ST_PMUL;
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		s_tready = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE:  s_tready = 1'b1;
			ST_BAR:   out_load = out_free;
			ST_PEMIT: out_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Step counter shared by both serial dividers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if ((state_q == ST_WDIV) || (state_q == ST_PDIV)) begin
			cnt_q <= (state_d != state_q) ? '0 : cnt_q + CNT_W'(1);
		end else begin
			cnt_q <= '0;
		end
	end

	// Sample history: add shifts in at the top, a render rotates once per point.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < HISTORY_DEPTH; k++) hist_q[k] <= '0;
		end else if (add_acc) begin
			for (int k = 0; k < HISTORY_DEPTH - 1; k++) hist_q[k] <= hist_q[k+1];
			hist_q[HISTORY_DEPTH-1] <= s_tdata[15:0];
		end else if (state_q == ST_PMUL) begin
			for (int k = 0; k < HISTORY_DEPTH - 1; k++) hist_q[k] <= hist_q[k+1];
			hist_q[HISTORY_DEPTH-1] <= hist_q[0];
		end
	end

	// Render context, captured on the render transaction.
	always_ff @(posedge clk) begin
		if (render_acc) begin
			ox_q  <= s_tdata[27:16];
			oy_q  <= s_tdata[39:28];
			w_q   <= s_tdata[51:40];
			h_q   <= s_tdata[63:52];
			off_q <= 27'($signed(s_tdata[39:28])) * 27'($signed({1'b0, fs_eff}));
		end
	end

	// Bit-serial divide of area_width by the history depth.
	logic [IW:0] wr2;
	logic        wge;
	assign wr2 = {wrem_q, wsh_q[COORD_W-1]};
	assign wge = (wr2 >= (IW+1)'(HISTORY_DEPTH));

	always_ff @(posedge clk) begin
		if (render_acc) begin
			wsh_q  <= s_tdata[51:40];
			wrem_q <= '0;
		end else if (state_q == ST_WDIV) begin
			wrem_q <= wge ? IW'(wr2 - (IW+1)'(HISTORY_DEPTH)) : IW'(wr2);
			wsh_q  <= {wsh_q[COORD_W-2:0], wge};
		end
	end

	// Clamp of the negated oldest sample and its product with the area height.
	logic signed [16:0] s_neg, s_clamp, fs_s;
	always_comb begin
		s_neg = -17'(hist_q[0]);
		fs_s  = {2'b00, fs_eff};
		if (s_neg > fs_s)       s_clamp = fs_s;
		else if (s_neg < -fs_s) s_clamp = -fs_s;
		else                    s_clamp = s_neg;
	end

	// Numerator, its sign and magnitude.
	logic signed [28:0] num;
	logic [28:0]        num_mag;
	assign num     = prod_q + 29'(off_q);
	assign num_mag = num[28] ? 29'(-num) : 29'(num);

	// Restoring division step: one quotient bit per cycle.
	logic [FS_W:0] r2;
	logic          ge;
	assign r2 = {rem_q, dsh_q[QUOT_W-1]};
	assign ge = (r2 >= {1'b0, fs_eff});

	always_ff @(posedge clk) begin
		case (state_q)
			ST_PMUL: prod_q <= 29'(s_clamp) * 29'($signed({1'b0, h_q}));
			ST_PSUM: begin
				neg_q <= num[28];
				rem_q <= num_mag[NUM_W-1:QUOT_W];
				dsh_q <= num_mag[QUOT_W-1:0];
			end
			ST_PDIV: begin
				rem_q <= ge ? FS_W'(r2 - {1'b0, fs_eff}) : FS_W'(r2);
				dsh_q <= {dsh_q[QUOT_W-2:0], ge};
			end
			default: ;
		endcase
	end

	// Current point and the rectangle from the previous one.
	logic signed [RECT_W-1:0] cx, cy;
	logic signed [RECT_W:0]   dy;
	logic [RECT_W:0]          dy_abs;
	logic [RECT_W-1:0]        rw, rh;
	always_comb begin
		cx     = RECT_W'(ox_q) + $signed({2'b00, qx_q});
		cy     = neg_q ? -$signed({1'b0, dsh_q}) : $signed({1'b0, dsh_q});
		dy     = (RECT_W+1)'(cy) - (RECT_W+1)'(py_q);
		dy_abs = dy[RECT_W] ? (RECT_W+1)'(-dy) : (RECT_W+1)'(dy);
		if (dy_abs == '0) dy_abs = (RECT_W+1)'(1);
		rw     = RECT_W'(cx - px_q) + RECT_W'(PAD);
		rh     = RECT_W'(dy_abs) + RECT_W'(PAD);
	end

	// X stepping: add the width quotient and carry the remainder.
	logic [IW:0] rsum;
	assign rsum = {1'b0, rx_q} + {1'b0, wrem_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (state_q == ST_BAR) begin
			idx_q <= '0;
		end else if ((state_q == ST_PEMIT) && out_free) begin
			idx_q <= idx_q + IW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_BAR) begin
			qx_q <= '0;
			rx_q <= '0;
			px_q <= RECT_W'(ox_q);
			py_q <= RECT_W'(oy_q);
		end else if ((state_q == ST_PEMIT) && out_free) begin
			px_q <= cx;
			py_q <= cy;
			if (rsum >= (IW+1)'(HISTORY_DEPTH)) begin
				rx_q <= IW'(rsum - (IW+1)'(HISTORY_DEPTH));
				qx_q <= qx_q + wsh_q + COORD_W'(1);
			end else begin
				rx_q <= IW'(rsum);
				qx_q <= qx_q + wsh_q;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (state_q == ST_BAR) begin
				ox_out_q <= RECT_W'(ox_q);
				oy_out_q <= RECT_W'(oy_q);
				ow_out_q <= RECT_W'(w_q);
				oh_out_q <= RECT_W'(PAD + 1);
				oc_out_q <= bar_color_q;
				olast_q  <= 1'b0;
			end else begin
				ox_out_q <= px_q;
				oy_out_q <= py_q;
				ow_out_q <= rw;
				oh_out_q <= rh;
				oc_out_q <= point_color_q;
				olast_q  <= last_pt;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {oc_out_q, oh_out_q, ow_out_q, oy_out_q, ox_out_q};
	assign m_tlast  = olast_q;

	// A new result appears only from the bar or point emit steps.
	a_load_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> ($past(state_q) == ST_BAR || $past(state_q) == ST_PEMIT))
		else $error("result loaded outside an emit step");

	// The partial remainder always stays below the divisor.
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PDIV) |-> (rem_q < fs_eff))
		else $error("divider remainder out of range");

	// The divider never runs past its quotient width.
	a_div_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PDIV) |-> (cnt_q <= CNT_W'(DIV_STEPS - 1)))
		else $error("divider step count overrun");

	// Emitting the last point ends the render and marks tlast.
	a_last_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PEMIT && out_load && last_pt) |=> (state_q == ST_IDLE && m_tlast))
		else $error("render did not end after the last point");

endmodule
